### design/nmeagga_pkg.sv
// Shared types, character codes and constants for the GGA sentence parser.
package nmeagga_pkg;

   localparam int HEADER_LEN  = 6;
   localparam int FRAC_DIGITS = 5;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_W     = 8'h57;

   localparam logic [3:0] FIELD_UTC  = 4'd1;
   localparam logic [3:0] FIELD_LAT  = 4'd2;
   localparam logic [3:0] FIELD_NS   = 4'd3;
   localparam logic [3:0] FIELD_LON  = 4'd4;
   localparam logic [3:0] FIELD_EW   = 4'd5;
   localparam logic [3:0] FIELD_FIX  = 4'd6;
   localparam logic [3:0] FIELD_SATS = 4'd7;
   localparam logic [3:0] FIELD_ALT  = 4'd9;

   localparam logic [19:0] UTC_MAX      = 20'd999999;
   localparam logic [7:0]  COUNT_MAX    = 8'd255;
   localparam logic [26:0] ALT_MAX      = 27'd99999999;
   localparam logic [9:0]  LAT_HUND_MAX = 10'd99;
   localparam logic [9:0]  LON_HUND_MAX = 10'd999;
   localparam logic [6:0]  REM_MAX      = 7'd99;

   localparam logic [25:0] MIN_SCALE5  = 26'd500000;
   localparam logic [33:0] DEG_SCALE   = 34'd10000000;
   localparam logic [25:0] DIV3_RECIP  = 26'd44739243;
   localparam int          DIV3_SHIFT  = 27;

   typedef struct packed {
      logic [9:0]  hund;
      logic [6:0]  rem;
      logic [16:0] frac;
      logic        negative;
   } coord_parts_type;

   typedef struct packed {
      logic [19:0]        utc_time;
      logic [7:0]         fix_quality;
      logic [7:0]         satellites;
      logic signed [27:0] altitude_cm;
   } fix_data_type;

   typedef struct packed {
      fix_data_type    data;
      coord_parts_type lat;
      coord_parts_type lon;
   } line_report_type;

   function automatic logic [7:0] header_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h24;
         3'd1:    ch = 8'h47;
         3'd2:    ch = 8'h50;
         3'd3:    ch = 8'h47;
         3'd4:    ch = 8'h47;
         default: ch = 8'h41;
      endcase
      return ch;
   endfunction

   function automatic logic [16:0] frac_weight(input logic [3:0] digit, input logic [2:0] pos);
      logic [16:0] scale;
      case (pos)
         3'd0:    scale = 17'd10000;
         3'd1:    scale = 17'd1000;
         3'd2:    scale = 17'd100;
         3'd3:    scale = 17'd10;
         default: scale = 17'd1;
      endcase
      return 17'({13'b0, digit} * scale);
   endfunction

   function automatic logic [16:0] push_whole(input logic [9:0] hund, input logic [6:0] rem,
                                              input logic [3:0] digit,
                                              input logic [9:0] hund_max);
      logic [9:0]  c;
      logic [3:0]  carry;
      logic [13:0] hund_next;
      logic [16:0] result;
      c = 10'({3'b0, rem} * 10'd10) + {6'b0, digit};
      carry = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         if (c >= 10'(100 * k)) begin
            carry = 4'(k);
         end
      end
      hund_next = 14'({4'b0, hund} * 14'd10) + {10'b0, carry};
      if (hund_next > {4'b0, hund_max}) begin
         result = {hund_max, REM_MAX};
      end else begin
         result = {hund_next[9:0], 7'(c - 10'({6'b0, carry} * 10'd100))};
      end
      return result;
   endfunction

endpackage

### design/nmea_gga_sentence_parser.sv
// GGA sentence parser top level: byte decoder, coordinate pipeline and result register.
// Accepts one received byte per cycle while ready is high; each byte updates the line state in the cycle it is taken.
// A qualifying line feed yields its result through a three-stage result pipeline (s1, s2, output register).
// Ready drops only when all three result stages are full and the result is stalled downstream.
// Synchronous active-high reset clears the line state and every stage valid flag.
module nmea_gga_sentence_parser #(
   parameter int MAX_LINE_CHARS = 255,
   parameter int MAX_FIELDS     = 15
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [19:0]        rsp_utc_time,
   output logic [7:0]         rsp_fix_quality,
   output logic [7:0]         rsp_satellites,
   output logic signed [27:0] rsp_altitude_cm,
   output logic signed [30:0] rsp_latitude_e7,
   output logic signed [34:0] rsp_longitude_e7
);

   logic                         req_accept;
   logic                         capture;
   nmeagga_pkg::line_report_type report;
   logic                         out_free;
   logic                         s2_free;
   logic                         s1_free;
   logic                         s1_valid_ff, s1_valid_in;
   logic                         s2_valid_ff, s2_valid_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   nmeagga_pkg::fix_data_type    s1_data_ff;
   nmeagga_pkg::fix_data_type    s2_data_ff;
   nmeagga_pkg::fix_data_type    rsp_data_ff;
   logic signed [34:0]           lat_value;
   logic signed [34:0]           lon_value;
   logic signed [30:0]           rsp_lat_ff, rsp_lat_in;
   logic signed [34:0]           rsp_lon_ff, rsp_lon_in;

   nmeagga_line_decoder #(
      .MAX_LINE_CHARS (MAX_LINE_CHARS),
      .MAX_FIELDS     (MAX_FIELDS)
   ) u_decoder (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (req_accept),
      .rx_byte      (req_rx_byte),
      .report_valid (capture),
      .report       (report)
   );

   nmeagga_coord_convert u_lat_convert (
      .clock   (clock),
      .load    (capture),
      .advance (s2_free),
      .parts   (report.lat),
      .value   (lat_value)
   );

   nmeagga_coord_convert u_lon_convert (
      .clock   (clock),
      .load    (capture),
      .advance (s2_free),
      .parts   (report.lon),
      .value   (lon_value)
   );

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      s2_free      = !s2_valid_ff || out_free;
      s1_free      = !s1_valid_ff || s2_free;
      req_ready    = s1_free;
      req_accept   = req_valid && s1_free;
      s1_valid_in  = s1_free ? capture : s1_valid_ff;
      s2_valid_in  = s2_free ? s1_valid_ff : s2_valid_ff;
      rsp_valid_in = out_free ? s2_valid_ff : rsp_valid_ff;
      rsp_lat_in   = lat_value[30:0];
      rsp_lon_in   = lon_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         s1_data_ff <= report.data;
      end
      if (s2_free) begin
         s2_data_ff <= s1_data_ff;
      end
      if (out_free) begin
         rsp_data_ff <= s2_data_ff;
         rsp_lat_ff  <= rsp_lat_in;
         rsp_lon_ff  <= rsp_lon_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_utc_time     = rsp_data_ff.utc_time;
   assign rsp_fix_quality  = rsp_data_ff.fix_quality;
   assign rsp_satellites   = rsp_data_ff.satellites;
   assign rsp_altitude_cm  = rsp_data_ff.altitude_cm;
   assign rsp_latitude_e7  = rsp_lat_ff;
   assign rsp_longitude_e7 = rsp_lon_ff;

`ifndef SYNTHESIS
   a_fix_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.fix_quality != 8'd0))
      else $error("result with zero fix quality");

   a_utc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.utc_time <= nmeagga_pkg::UTC_MAX))
      else $error("utc time out of range");

   a_alt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.altitude_cm <= 28'sd99999999)
                        && (rsp_data_ff.altitude_cm >= -28'sd99999999)))
      else $error("altitude out of range");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s2_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled with free result stage");

   a_capture_held: assert property (@(posedge clock) disable iff (reset)
      capture |=> s1_valid_ff)
      else $error("captured transaction lost");
`endif

endmodule

### design/nmeagga_line_decoder.sv
// Per-character field decoder holding the running line state and accumulators.
module nmeagga_line_decoder #(
   parameter int MAX_LINE_CHARS = 255,
   parameter int MAX_FIELDS     = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          byte_valid,
   input  logic [7:0]                    rx_byte,
   output logic                          report_valid,
   output nmeagga_pkg::line_report_type  report
);

   localparam int LINE_W = $clog2(MAX_LINE_CHARS + 1);

   logic [LINE_W-1:0] line_length_ff, line_length_in;
   logic [2:0]  header_match_pos_ff, header_match_pos_in;
   logic        header_mismatch_ff, header_mismatch_in;
   logic [3:0]  field_index_ff, field_index_in;
   logic        number_stopped_ff, number_stopped_in;
   logic [2:0]  fraction_digits_ff, fraction_digits_in;
   logic        in_fraction_ff, in_fraction_in;
   logic        field_started_ff, field_started_in;
   logic [19:0] utc_accum_ff, utc_accum_in;
   logic [7:0]  fix_accum_ff, fix_accum_in;
   logic [7:0]  sats_accum_ff, sats_accum_in;
   logic [26:0] alt_accum_ff, alt_accum_in;
   logic        alt_negative_ff, alt_negative_in;
   logic [9:0]  lat_hund_ff, lat_hund_in;
   logic [6:0]  lat_rem_ff, lat_rem_in;
   logic [16:0] lat_fraction_ff, lat_fraction_in;
   logic        lat_south_ff, lat_south_in;
   logic [9:0]  lon_hund_ff, lon_hund_in;
   logic [6:0]  lon_rem_ff, lon_rem_in;
   logic [16:0] lon_fraction_ff, lon_fraction_in;
   logic        lon_west_ff, lon_west_in;

   logic        is_digit;
   logic        printable;
   logic        numeric_field;
   logic        first;
   logic [3:0]  digit;
   logic [23:0] utc_next;
   logic [11:0] fix_next;
   logic [11:0] sats_next;
   logic [29:0] alt_next;
   logic [27:0] alt_frac_next;
   logic [16:0] lat_whole_next;
   logic [16:0] lon_whole_next;

   always_comb begin
      line_length_in      = line_length_ff;
      header_match_pos_in = header_match_pos_ff;
      header_mismatch_in  = header_mismatch_ff;
      field_index_in      = field_index_ff;
      number_stopped_in   = number_stopped_ff;
      fraction_digits_in  = fraction_digits_ff;
      in_fraction_in      = in_fraction_ff;
      field_started_in    = field_started_ff;
      utc_accum_in        = utc_accum_ff;
      fix_accum_in        = fix_accum_ff;
      sats_accum_in       = sats_accum_ff;
      alt_accum_in        = alt_accum_ff;
      alt_negative_in     = alt_negative_ff;
      lat_hund_in         = lat_hund_ff;
      lat_rem_in          = lat_rem_ff;
      lat_fraction_in     = lat_fraction_ff;
      lat_south_in        = lat_south_ff;
      lon_hund_in         = lon_hund_ff;
      lon_rem_in          = lon_rem_ff;
      lon_fraction_in     = lon_fraction_ff;
      lon_west_in         = lon_west_ff;
      report_valid        = 1'b0;

      digit     = rx_byte[3:0];
      is_digit  = (rx_byte >= nmeagga_pkg::CHAR_ZERO) && (rx_byte <= nmeagga_pkg::CHAR_NINE);
      printable = (rx_byte >= nmeagga_pkg::CHAR_SPACE) && (rx_byte <= nmeagga_pkg::CHAR_TILDE);
      first     = !field_started_ff;
      numeric_field = (field_index_ff == nmeagga_pkg::FIELD_UTC)
                   || (field_index_ff == nmeagga_pkg::FIELD_LAT)
                   || (field_index_ff == nmeagga_pkg::FIELD_LON)
                   || (field_index_ff == nmeagga_pkg::FIELD_FIX)
                   || (field_index_ff == nmeagga_pkg::FIELD_SATS)
                   || (field_index_ff == nmeagga_pkg::FIELD_ALT);

      utc_next  = 24'({4'b0, utc_accum_ff} * 24'd10) + {20'b0, digit};
      fix_next  = 12'({4'b0, fix_accum_ff} * 12'd10) + {8'b0, digit};
      sats_next = 12'({4'b0, sats_accum_ff} * 12'd10) + {8'b0, digit};
      alt_next  = 30'({3'b0, alt_accum_ff} * 30'd10) + 30'({26'b0, digit} * 30'd100);
      alt_frac_next = {1'b0, alt_accum_ff}
                    + ((fraction_digits_ff == 3'd0) ? 28'({24'b0, digit} * 28'd10)
                                                    : {24'b0, digit});
      lat_whole_next = nmeagga_pkg::push_whole(lat_hund_ff, lat_rem_ff, digit,
                                               nmeagga_pkg::LAT_HUND_MAX);
      lon_whole_next = nmeagga_pkg::push_whole(lon_hund_ff, lon_rem_ff, digit,
                                               nmeagga_pkg::LON_HUND_MAX);

      if (byte_valid) begin
         if (rx_byte == nmeagga_pkg::CHAR_LF) begin
            report_valid = (header_match_pos_ff == 3'(nmeagga_pkg::HEADER_LEN))
                        && !header_mismatch_ff
                        && (field_index_ff >= nmeagga_pkg::FIELD_ALT)
                        && (fix_accum_ff != 8'd0);
            line_length_in      = '0;
            header_match_pos_in = '0;
            header_mismatch_in  = 1'b0;
            field_index_in      = '0;
            number_stopped_in   = 1'b0;
            fraction_digits_in  = '0;
            in_fraction_in      = 1'b0;
            field_started_in    = 1'b0;
            utc_accum_in        = '0;
            fix_accum_in        = '0;
            sats_accum_in       = '0;
            alt_accum_in        = '0;
            alt_negative_in     = 1'b0;
            lat_hund_in         = '0;
            lat_rem_in          = '0;
            lat_fraction_in     = '0;
            lat_south_in        = 1'b0;
            lon_hund_in         = '0;
            lon_rem_in          = '0;
            lon_fraction_in     = '0;
            lon_west_in         = 1'b0;
         end else if (printable && (line_length_ff < LINE_W'(MAX_LINE_CHARS))) begin
            if (line_length_ff < LINE_W'(nmeagga_pkg::HEADER_LEN)) begin
               if (rx_byte != nmeagga_pkg::header_char(line_length_ff[2:0])) begin
                  header_mismatch_in = 1'b1;
               end
               header_match_pos_in = line_length_ff[2:0] + 3'd1;
            end
            line_length_in = line_length_ff + LINE_W'(1);

            if (rx_byte == nmeagga_pkg::CHAR_COMMA) begin
               if (field_index_ff < 4'(MAX_FIELDS)) begin
                  field_index_in = field_index_ff + 4'd1;
               end
               number_stopped_in  = 1'b0;
               fraction_digits_in = '0;
               in_fraction_in     = 1'b0;
               field_started_in   = 1'b0;
            end else begin
               field_started_in = 1'b1;
               if (field_index_ff == nmeagga_pkg::FIELD_NS) begin
                  if (first && (rx_byte == nmeagga_pkg::CHAR_S)) begin
                     lat_south_in = 1'b1;
                  end
               end else if (field_index_ff == nmeagga_pkg::FIELD_EW) begin
                  if (first && (rx_byte == nmeagga_pkg::CHAR_W)) begin
                     lon_west_in = 1'b1;
                  end
               end else if (numeric_field && !number_stopped_ff) begin
                  if (is_digit) begin
                     if (!in_fraction_ff) begin
                        unique case (field_index_ff)
                           nmeagga_pkg::FIELD_UTC: begin
                              utc_accum_in = (utc_next > {4'b0, nmeagga_pkg::UTC_MAX})
                                           ? nmeagga_pkg::UTC_MAX : utc_next[19:0];
                           end
                           nmeagga_pkg::FIELD_FIX: begin
                              fix_accum_in = (fix_next > {4'b0, nmeagga_pkg::COUNT_MAX})
                                           ? nmeagga_pkg::COUNT_MAX : fix_next[7:0];
                           end
                           nmeagga_pkg::FIELD_SATS: begin
                              sats_accum_in = (sats_next > {4'b0, nmeagga_pkg::COUNT_MAX})
                                            ? nmeagga_pkg::COUNT_MAX : sats_next[7:0];
                           end
                           nmeagga_pkg::FIELD_ALT: begin
                              alt_accum_in = (alt_next > {3'b0, nmeagga_pkg::ALT_MAX})
                                           ? nmeagga_pkg::ALT_MAX : alt_next[26:0];
                           end
                           nmeagga_pkg::FIELD_LAT: begin
                              lat_hund_in = lat_whole_next[16:7];
                              lat_rem_in  = lat_whole_next[6:0];
                           end
                           default: begin
                              lon_hund_in = lon_whole_next[16:7];
                              lon_rem_in  = lon_whole_next[6:0];
                           end
                        endcase
                     end else if (field_index_ff == nmeagga_pkg::FIELD_ALT) begin
                        if (fraction_digits_ff < 3'd2) begin
                           alt_accum_in = (alt_frac_next > {1'b0, nmeagga_pkg::ALT_MAX})
                                        ? nmeagga_pkg::ALT_MAX : alt_frac_next[26:0];
                           fraction_digits_in = fraction_digits_ff + 3'd1;
                        end
                     end else if (fraction_digits_ff < 3'(nmeagga_pkg::FRAC_DIGITS)) begin
                        fraction_digits_in = fraction_digits_ff + 3'd1;
                        if (field_index_ff == nmeagga_pkg::FIELD_LAT) begin
                           lat_fraction_in = lat_fraction_ff
                                           + nmeagga_pkg::frac_weight(digit, fraction_digits_ff);
                        end else begin
                           lon_fraction_in = lon_fraction_ff
                                           + nmeagga_pkg::frac_weight(digit, fraction_digits_ff);
                        end
                     end
                  end else if ((rx_byte == nmeagga_pkg::CHAR_DOT) && !in_fraction_ff
                               && ((field_index_ff == nmeagga_pkg::FIELD_LAT)
                                   || (field_index_ff == nmeagga_pkg::FIELD_LON)
                                   || (field_index_ff == nmeagga_pkg::FIELD_ALT))) begin
                     in_fraction_in = 1'b1;
                  end else if (!(first && (rx_byte == nmeagga_pkg::CHAR_PLUS))) begin
                     if (first && (rx_byte == nmeagga_pkg::CHAR_MINUS)
                         && (field_index_ff == nmeagga_pkg::FIELD_ALT)) begin
                        alt_negative_in = 1'b1;
                     end else begin
                        number_stopped_in = 1'b1;
                     end
                  end
               end
            end
         end
      end
   end

   always_comb begin
      report.data.utc_time    = utc_accum_ff;
      report.data.fix_quality = fix_accum_ff;
      report.data.satellites  = sats_accum_ff;
      report.data.altitude_cm = alt_negative_ff ? -$signed({1'b0, alt_accum_ff})
                                                : $signed({1'b0, alt_accum_ff});
      report.lat = '{hund: lat_hund_ff, rem: lat_rem_ff, frac: lat_fraction_ff,
                     negative: lat_south_ff};
      report.lon = '{hund: lon_hund_ff, rem: lon_rem_ff, frac: lon_fraction_ff,
                     negative: lon_west_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff      <= '0;
         header_match_pos_ff <= '0;
         header_mismatch_ff  <= 1'b0;
         field_index_ff      <= '0;
         number_stopped_ff   <= 1'b0;
         fraction_digits_ff  <= '0;
         in_fraction_ff      <= 1'b0;
         field_started_ff    <= 1'b0;
         utc_accum_ff        <= '0;
         fix_accum_ff        <= '0;
         sats_accum_ff       <= '0;
         alt_accum_ff        <= '0;
         alt_negative_ff     <= 1'b0;
         lat_hund_ff         <= '0;
         lat_rem_ff          <= '0;
         lat_fraction_ff     <= '0;
         lat_south_ff        <= 1'b0;
         lon_hund_ff         <= '0;
         lon_rem_ff          <= '0;
         lon_fraction_ff     <= '0;
         lon_west_ff         <= 1'b0;
      end else begin
         line_length_ff      <= line_length_in;
         header_match_pos_ff <= header_match_pos_in;
         header_mismatch_ff  <= header_mismatch_in;
         field_index_ff      <= field_index_in;
         number_stopped_ff   <= number_stopped_in;
         fraction_digits_ff  <= fraction_digits_in;
         in_fraction_ff      <= in_fraction_in;
         field_started_ff    <= field_started_in;
         utc_accum_ff        <= utc_accum_in;
         fix_accum_ff        <= fix_accum_in;
         sats_accum_ff       <= sats_accum_in;
         alt_accum_ff        <= alt_accum_in;
         alt_negative_ff     <= alt_negative_in;
         lat_hund_ff         <= lat_hund_in;
         lat_rem_ff          <= lat_rem_in;
         lat_fraction_ff     <= lat_fraction_in;
         lat_south_ff        <= lat_south_in;
         lon_hund_ff         <= lon_hund_in;
         lon_rem_ff          <= lon_rem_in;
         lon_fraction_ff     <= lon_fraction_in;
         lon_west_ff         <= lon_west_in;
      end
   end

endmodule

### design/nmeagga_coord_convert.sv
// Two-stage conversion of degree/minute parts into signed 1e-7 degree units.
module nmeagga_coord_convert (
   input  logic                          clock,
   input  logic                          load,
   input  logic                          advance,
   input  nmeagga_pkg::coord_parts_type  parts,
   output logic signed [34:0]            value
);

   logic [25:0] scaled_min_ff, scaled_min_in;
   logic [33:0] deg1_ff, deg1_in;
   logic        neg1_ff;
   logic [51:0] product;
   logic [24:0] third_ff, third_in;
   logic [33:0] deg2_ff;
   logic        neg2_ff;
   logic [34:0] magnitude;

   always_comb begin
      scaled_min_in = ({19'b0, parts.rem} * nmeagga_pkg::MIN_SCALE5)
                    + 26'({9'b0, parts.frac} * 26'd5);
      deg1_in       = {24'b0, parts.hund} * nmeagga_pkg::DEG_SCALE;
      product       = {26'b0, scaled_min_ff} * {26'b0, nmeagga_pkg::DIV3_RECIP};
      third_in      = product[nmeagga_pkg::DIV3_SHIFT +: 25];
      magnitude     = {1'b0, deg2_ff} + {10'b0, third_ff};
      value         = neg2_ff ? -$signed(magnitude) : $signed(magnitude);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         scaled_min_ff <= scaled_min_in;
         deg1_ff       <= deg1_in;
         neg1_ff       <= parts.negative;
      end
      if (advance) begin
         third_ff <= third_in;
         deg2_ff  <= deg1_ff;
         neg2_ff  <= neg1_ff;
      end
   end

endmodule

### dv/nmea_gga_sentence_parser_tb.sv
// Self-checking testbench for the GGA sentence parser: byte stream in, fix reports checked.
module nmea_gga_sentence_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import nmeagga_pkg::*;

   localparam int          LINE_CAP      = 255;
   localparam int          FIELD_CAP     = 15;
   localparam int          LAT_WHOLE_CAP = 9999;
   localparam int          LON_WHOLE_CAP = 99999;
   localparam logic [47:0] GGA_TAG       = "$GPGGA";
   localparam logic [7:0]  CHAR_CR       = 8'h0D;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          DRAIN_LIMIT   = 4000;
   localparam int          DRAIN_TAIL    = 20;

   typedef struct packed {
      logic [19:0]        utc_time;
      logic [7:0]         fix_quality;
      logic [7:0]         satellites;
      logic signed [27:0] altitude_cm;
      logic signed [30:0] latitude_e7;
      logic signed [34:0] longitude_e7;
   } gga_fix_t;

   class gga_fix_scoreboard;
      int        line_len;
      int        tag_pos;
      bit        tag_bad;
      bit [3:0]  field_no;
      bit        num_done;
      bit        in_frac;
      bit        field_busy;
      int        frac_cnt;
      bit [19:0] utc;
      bit [7:0]  fixq;
      bit [7:0]  sats;
      bit [26:0] alt_mag;
      bit        alt_neg;
      bit [13:0] lat_int;
      bit [16:0] lat_frac;
      int        lat_len;
      bit        lat_neg;
      bit [16:0] lon_int;
      bit [16:0] lon_frac;
      int        lon_len;
      bit        lon_neg;
      gga_fix_t  pending_fixes[$];
      int        mismatches;
      int        fix_count;
      int        byte_count;

      function void clear_field();
         num_done   = 0;
         in_frac    = 0;
         field_busy = 0;
         frac_cnt   = 0;
      endfunction

      function void clear_line();
         clear_field();
         line_len = 0;
         tag_pos  = 0;
         tag_bad  = 0;
         field_no = 0;
         utc      = 0;
         fixq     = 0;
         sats     = 0;
         alt_mag  = 0;
         alt_neg  = 0;
         lat_int  = 0;
         lat_frac = 0;
         lat_len  = 0;
         lat_neg  = 0;
         lon_int  = 0;
         lon_frac = 0;
         lon_len  = 0;
         lon_neg  = 0;
      endfunction

      function longint unsigned sat_push(longint unsigned acc, int unsigned d,
                                         int unsigned mult, longint unsigned cap);
         longint unsigned v;
         v = acc * 10 + d * mult;
         return (v > cap) ? cap : v;
      endfunction

      function longint coord_e7(longint unsigned whole, longint unsigned frac, int n, bit neg);
         longint unsigned unit;
         longint unsigned part;
         longint unsigned mag;
         unit = 1;
         repeat (FRAC_DIGITS) unit *= 10;
         part = frac;
         repeat (FRAC_DIGITS - n) part *= 10;
         part += (whole % 100) * unit;
         mag = (whole / 100) * 64'd10000000 + part * 64'd10000000 / (60 * unit);
         return neg ? -$signed(mag) : $signed(mag);
      endfunction

      function void take_digit(int unsigned d);
         longint unsigned v;
         if (!in_frac) begin
            case (field_no)
               FIELD_UTC:  utc = sat_push(utc, d, 1, UTC_MAX);
               FIELD_FIX:  fixq = sat_push(fixq, d, 1, COUNT_MAX);
               FIELD_SATS: sats = sat_push(sats, d, 1, COUNT_MAX);
               FIELD_ALT:  alt_mag = sat_push(alt_mag, d, 100, ALT_MAX);
               FIELD_LAT:  lat_int = sat_push(lat_int, d, 1, LAT_WHOLE_CAP);
               default:    lon_int = sat_push(lon_int, d, 1, LON_WHOLE_CAP);
            endcase
         end else if (field_no == FIELD_ALT) begin
            if (frac_cnt < 2) begin
               v = alt_mag + d * ((frac_cnt == 0) ? 10 : 1);
               alt_mag = (v > ALT_MAX) ? ALT_MAX : v;
               frac_cnt++;
            end
         end else if (frac_cnt < FRAC_DIGITS) begin
            frac_cnt++;
            if (field_no == FIELD_LAT) begin
               lat_frac = lat_frac * 10 + d;
               lat_len  = frac_cnt;
            end else begin
               lon_frac = lon_frac * 10 + d;
               lon_len  = frac_cnt;
            end
         end
      endfunction

      function void note_byte(logic [7:0] c);
         gga_fix_t r;
         bit       first;
         longint   alt;
         longint   lat;
         longint   lon;
         if (c == CHAR_LF) begin
            byte_count++;
            if (tag_pos == HEADER_LEN && !tag_bad && field_no >= FIELD_ALT && fixq != 0) begin
               alt = alt_mag;
               if (alt_neg) alt = -alt;
               lat = coord_e7(lat_int, lat_frac, lat_len, lat_neg);
               lon = coord_e7(lon_int, lon_frac, lon_len, lon_neg);
               r.utc_time     = utc;
               r.fix_quality  = fixq;
               r.satellites   = sats;
               r.altitude_cm  = alt[27:0];
               r.latitude_e7  = lat[30:0];
               r.longitude_e7 = lon[34:0];
               pending_fixes.push_back(r);
               fix_count++;
            end
            clear_line();
            return;
         end
         if (c < CHAR_SPACE || c > CHAR_TILDE || line_len >= LINE_CAP) return;
         byte_count++;
         if (line_len < HEADER_LEN) begin
            if (c != GGA_TAG[47 - 8 * line_len -: 8]) tag_bad = 1;
            tag_pos = line_len + 1;
         end
         line_len++;
         if (c == CHAR_COMMA) begin
            if (field_no < FIELD_CAP) field_no++;
            clear_field();
            return;
         end
         first = !field_busy;
         field_busy = 1;
         case (field_no)
            FIELD_NS: begin
               if (first && c == CHAR_S) lat_neg = 1;
               return;
            end
            FIELD_EW: begin
               if (first && c == CHAR_W) lon_neg = 1;
               return;
            end
            FIELD_UTC, FIELD_LAT, FIELD_LON, FIELD_FIX, FIELD_SATS, FIELD_ALT: begin
            end
            default: return;
         endcase
         if (num_done) return;
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            take_digit(c - CHAR_ZERO);
         end else if (c == CHAR_DOT && !in_frac && (field_no == FIELD_LAT ||
                      field_no == FIELD_LON || field_no == FIELD_ALT)) begin
            in_frac = 1;
         end else if (first && c == CHAR_PLUS) begin
         end else if (first && c == CHAR_MINUS && field_no == FIELD_ALT) begin
            alt_neg = 1;
         end else begin
            num_done = 1;
         end
      endfunction

      function void check_fix(gga_fix_t got);
         gga_fix_t want;
         if (pending_fixes.size() == 0) begin
            $error("unexpected fix report, utc_time %0d", got.utc_time);
            mismatches++;
            return;
         end
         want = pending_fixes.pop_front();
         if (got.utc_time !== want.utc_time) begin
            $error("utc_time: expected %0d, got %0d", want.utc_time, got.utc_time);
            mismatches++;
         end
         if (got.fix_quality !== want.fix_quality) begin
            $error("fix_quality: expected %0d, got %0d", want.fix_quality, got.fix_quality);
            mismatches++;
         end
         if (got.satellites !== want.satellites) begin
            $error("satellites: expected %0d, got %0d", want.satellites, got.satellites);
            mismatches++;
         end
         if (got.altitude_cm !== want.altitude_cm) begin
            $error("altitude_cm: expected %0d, got %0d", want.altitude_cm, got.altitude_cm);
            mismatches++;
         end
         if (got.latitude_e7 !== want.latitude_e7) begin
            $error("latitude_e7: expected %0d, got %0d", want.latitude_e7, got.latitude_e7);
            mismatches++;
         end
         if (got.longitude_e7 !== want.longitude_e7) begin
            $error("longitude_e7: expected %0d, got %0d", want.longitude_e7,
                   got.longitude_e7);
            mismatches++;
         end
      endfunction
   endclass

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_ready   = 1'b0;
   logic [19:0]        rsp_utc_time;
   logic [7:0]         rsp_fix_quality;
   logic [7:0]         rsp_satellites;
   logic signed [27:0] rsp_altitude_cm;
   logic signed [30:0] rsp_latitude_e7;
   logic signed [34:0] rsp_longitude_e7;

   gga_fix_scoreboard sb;
   int                gap_pct   = 0;
   int                stall_pct = 0;
   bit                hold_rsp  = 1'b0;

   nmea_gga_sentence_parser #(
      .MAX_LINE_CHARS(LINE_CAP),
      .MAX_FIELDS    (FIELD_CAP)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_utc_time    (rsp_utc_time),
      .rsp_fix_quality (rsp_fix_quality),
      .rsp_satellites  (rsp_satellites),
      .rsp_altitude_cm (rsp_altitude_cm),
      .rsp_latitude_e7 (rsp_latitude_e7),
      .rsp_longitude_e7(rsp_longitude_e7)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_fix({rsp_utc_time, rsp_fix_quality, rsp_satellites, rsp_altitude_cm,
                          rsp_latitude_e7, rsp_longitude_e7});
         end
         if (req_valid && req_ready) begin
            sb.note_byte(req_rx_byte);
         end
      end
   end

   // hold off the result channel on request, otherwise stall at random
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_text(input string s, input int junk_pct);
      logic [7:0] b;
      for (int i = 0; i < s.len(); i++) begin
         if ($urandom_range(99) < junk_pct) begin
            do b = 8'($urandom_range(255)); while (b == CHAR_LF);
            send_byte(b);
         end
         send_byte(s[i]);
      end
   endtask

   task automatic send_line(input string s);
      send_text(s, 0);
      send_byte(CHAR_LF);
   endtask

   function automatic string rand_digits(int n);
      string s;
      s = "";
      repeat (n) s = $sformatf("%s%c", s, 8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
      return s;
   endfunction

   function automatic string filler(int n);
      string      s;
      logic [7:0] ch;
      s = "";
      repeat (n) begin
         do ch = 8'($urandom_range(CHAR_SPACE, CHAR_TILDE)); while (ch == CHAR_COMMA);
         s = $sformatf("%s%c", s, ch);
      end
      return s;
   endfunction

   function automatic string rand_num(int whole_max, int frac_max);
      string s;
      string tail;
      int    r;
      s    = "";
      tail = "+-.A/ ";
      r    = $urandom_range(99);
      if (r < 8) return s;
      if (r < 14) s = "+";
      else if (r < 20) s = "-";
      s = {s, rand_digits($urandom_range(whole_max))};
      if ($urandom_range(99) < 55) s = {s, ".", rand_digits($urandom_range(frac_max))};
      if ($urandom_range(99) < 10) begin
         s = $sformatf("%s%c%s", s, tail[$urandom_range(5)], rand_digits($urandom_range(3)));
      end
      return s;
   endfunction

   function automatic string hemi(string pos, string neg);
      int r;
      r = $urandom_range(99);
      if (r < 45) return pos;
      if (r < 90) return neg;
      if (r < 95) return "";
      return {"x", neg};
   endfunction

   task automatic send_sentence(input int junk_pct);
      string f[20];
      string line;
      int    n;
      int    r;
      r = $urandom_range(99);
      f[0]  = (r < 85) ? "$GPGGA" : (r < 90) ? "$GPGGAX" : (r < 95) ? "$GNGGA" : "$GPGG";
      f[1]  = rand_num(8, 3);
      f[2]  = rand_num(6, 7);
      f[3]  = hemi("N", "S");
      f[4]  = rand_num(7, 7);
      f[5]  = hemi("E", "W");
      r = $urandom_range(99);
      f[6]  = (r < 75) ? $sformatf("%0d", $urandom_range(1, 8)) : (r < 85) ? "0"
                                                                         : rand_num(4, 2);
      f[7]  = rand_num(3, 1);
      f[8]  = ($urandom_range(99) < 4) ? filler($urandom_range(200, 300)) : "0.9";
      f[9]  = rand_num(10, 4);
      f[10] = "M";
      f[11] = rand_num(3, 1);
      f[12] = "M";
      f[13] = "";
      f[14] = ($urandom_range(99) < 4) ? filler($urandom_range(200, 300)) : "0000";
      for (int i = 15; i < 20; i++) f[i] = rand_num(2, 1);
      r = $urandom_range(99);
      n = (r < 80) ? 15 : (r < 90) ? $urandom_range(8, 14) : $urandom_range(16, 20);
      line = f[0];
      for (int i = 1; i < n; i++) line = {line, ",", f[i]};
      if ($urandom_range(1) == 1) line = {line, $sformatf("*%02X", $urandom_range(255))};
      send_text(line, junk_pct);
      if ($urandom_range(99) < 85) send_byte(CHAR_CR);
      send_byte(CHAR_LF);
   endtask

   initial begin
      int target_bytes;
      int target_fixes;
      int r;
      int waited;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_line("$GPGGA,123519.00,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47");
      send_line("$GPGGA,99999999,99999.9999999,S,999999.99999,W,999,999,0.9,-9999999999.999,M");
      send_line("$GPGGA,,,,,,1,,,,");
      send_line("$GPGGA,,,,,,1,,,");
      send_line("$GPGGAX,000001,0000.00001,N,00000.00001,E,2,00,,+0.01,M");
      send_line("$GPGGB,1,,,,,1,,,,");
      send_line("$GPGG,1,,,,,1,,,,");
      send_line("$GPGGA,1,,,,,0,,,,");
      send_line("$GPGGA,1,,,,,-1,,,,");
      send_line("$GPGGA,+12.5,-4807.0,South,+01131.5.5,West,+3x,1.5,,-12.345x9,M");
      send_line("$GPGGA,7,,xS,,xW,300,256,,+.5,,,,,,,,,,,,9,9");
      send_line("$GPGGA,235959,0000.0,N,00000.0,E,8,12,,-.07");
      send_text("$GPGGA,12", 0);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h7F);
      send_byte(8'h80);
      send_byte(CHAR_CR);
      send_line("34,,,,,1,,,,");
      // altitude straddles the line length limit
      send_line({"$GPGGA,1,2,N,3,E,1,2,", filler(231), ",987"});
      send_byte(CHAR_LF);
      send_byte(CHAR_LF);

      target_bytes = 0;
      target_fixes = 0;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 47; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 47; end
            default: begin gap_pct = 26; stall_pct = 26; end
         endcase
         target_bytes += 225;
         target_fixes += 12;
         while (sb.byte_count < target_bytes || sb.fix_count < target_fixes) begin
            r = $urandom_range(99);
            if (r < 88) begin
               send_sentence((r < 10) ? 3 : 0);
            end else begin
               repeat ($urandom_range(1, 40)) send_byte(8'($urandom_range(255)));
               if (r < 94) send_byte(CHAR_LF);
            end
         end
      end

      // back-pressure: stall results while lines keep coming
      gap_pct   = 0;
      stall_pct = 0;
      hold_rsp  = 1'b1;
      repeat (12) begin
         send_line($sformatf("$GPGGA,%0d,%0d.%0d,S,,W,%0d,%0d,,%0d", $urandom_range(999999),
                             $urandom_range(9999), $urandom_range(99999),
                             $urandom_range(1, 9), $urandom_range(99),
                             $urandom_range(99999)));
      end
      req_valid <= 1'b0;

      waited = 0;
      while (sb.pending_fixes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_TAIL) @(posedge clock);
      if (sb.pending_fixes.size() != 0) begin
         $error("%0d fix reports never arrived", sb.pending_fixes.size());
         sb.mismatches++;
      end
      if (sb.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
